FILE: rtl/sm3_pkg.sv
// Package for the SM3 hash engine: widths, constants, command types and round helpers.
// Depends on nothing; every rtl file uses it.
`timescale 1ns / 1ps
package sm3_pkg;

    localparam int WORD_W      = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int BLOCK_WORDS = 16;

    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [255:0] SM3_IV = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    // One command from the front end: a word to load into the block buffer,
    // optionally followed by finishing the message.
    typedef struct packed {
        logic [31:0] word;
        logic        pad_start;  // this word carries the 0x80 byte
        logic        finish;     // after loading this word, pad and emit digest
        logic        pad_next;   // 0x80 must start the next word (four full bytes)
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PADWORD,
        ST_ZERO,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_EMIT
    } back_state_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

FILE: rtl/sm3_hash_engine.sv
// Top level of the streaming SM3 hash engine: joins the front end queue and the back end.
// Depends on sm3_pkg, sm3_front and sm3_back.
//
//   channel   direction  handshake        payload
//   input     in         push / full      data_word, valid_bytes, last_word
//   result    out        pop / empty      digest_part, part_index, part_last
//
// Each beat loads one word into the block buffer; every sixteenth word
// starts a compression, one SM3 round per cycle, during which the back end takes
// no new words. The last beat adds padding words one a cycle and one or two
// compressions, after which four digest beats are offered.
// Reset clears the queue, the sequencer and restores the initial chaining value.
// Input beats keep queueing while the back end compresses or waits on pop.
`timescale 1ns / 1ps
module sm3_hash_engine #(
    parameter int QUEUE_DEPTH = sm3_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last_word,
    input  logic        push,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] digest_part,
    output logic [1:0]  part_index,
    output logic        part_last
);
    sm3_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_take;
    logic [3:0]    cmd_bytes;

    // Front end: masks the final word, inserts the padding byte and queues commands.
    sm3_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .data_word(data_word), .valid_bytes(valid_bytes), .last_word(last_word),
        .push(push), .full(full),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_bytes(cmd_bytes), .cmd_take(cmd_take)
    );

    // Back end: block buffer, padding sequencer, round unit and digest register.
    sm3_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd(cmd), .cmd_bytes(cmd_bytes), .cmd_take(cmd_take),
        .empty(empty), .pop(pop),
        .digest_part(digest_part), .part_index(part_index), .part_last(part_last)
    );
endmodule

FILE: rtl/sm3_front.sv
// Front end of the SM3 hash engine: masks and classifies input beats into commands
// and holds them in a short queue for the back end. Depends on sm3_pkg.
`timescale 1ns / 1ps
module sm3_front #(
    parameter int QUEUE_DEPTH = sm3_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        data_word,
    input  logic [2:0]         valid_bytes,
    input  logic               last_word,
    input  logic               push,
    output logic               full,
    output logic               cmd_valid,
    output sm3_pkg::cmd_t      cmd,
    output logic [3:0]         cmd_bytes,
    input  logic               cmd_take
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef struct packed {
        sm3_pkg::cmd_t c;
        logic [3:0]    nbytes;
    } entry_t;

    entry_t            queue_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]       count_reg;
    entry_t            new_entry;
    logic [2:0]        nb;
    logic [31:0]       mask;
    logic              do_push, do_pop;

    always_comb
    begin
        nb = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
        if (!last_word)
            nb = 3'd4;
        case (nb)
            3'd0:    mask = 32'h00000000;
            3'd1:    mask = 32'hFF000000;
            3'd2:    mask = 32'hFFFF0000;
            3'd3:    mask = 32'hFFFFFF00;
            default: mask = 32'hFFFFFFFF;
        endcase
        new_entry.c.word      = data_word & mask;
        new_entry.c.pad_start = 1'b0;
        new_entry.c.finish    = last_word;
        new_entry.c.pad_next  = last_word && (nb == 3'd4);
        new_entry.nbytes      = {1'b0, nb};
        if (last_word && nb != 3'd4)
        begin
            new_entry.c.pad_start = 1'b1;
            new_entry.c.word = new_entry.c.word
                | ({24'd0, sm3_pkg::PAD_BYTE} << (5'd24 - {nb[1:0], 3'd0}));
        end
    end

    assign full      = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg].c;
    assign cmd_bytes = queue_reg[rd_ptr_reg].nbytes;
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            queue_reg[wr_ptr_reg] <= new_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end
endmodule

FILE: rtl/sm3_back.sv
// Back end of the SM3 hash engine: block buffer, padding sequencer, one-round-per-cycle
// compression and the digest output register. Depends on sm3_pkg.
`timescale 1ns / 1ps
module sm3_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  sm3_pkg::cmd_t      cmd,
    input  logic [3:0]         cmd_bytes,
    output logic               cmd_take,
    output logic               empty,
    input  logic               pop,
    output logic [63:0]        digest_part,
    output logic [1:0]         part_index,
    output logic               part_last
);
    sm3_pkg::back_state_t state_reg, state_next;

    logic [31:0] w_reg [16];       // sliding message schedule window
    logic [31:0] v_reg [8];        // chaining value
    logic [31:0] r_reg [8];        // working registers A..H
    logic [3:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [6:0]  round_reg;
    logic        finish_reg;       // message ending: continue padding after compress
    logic        pad_next_reg;     // the 0x80 word is still owed after this compress
    logic [1:0]  part_reg;
    logic        empty_reg;

    // word load request for this cycle
    logic        load;
    logic [31:0] load_word;
    logic        start_cmp;
    logic        last_round;

    // round datapath
    logic        early;
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, wn;

    always_comb
    begin
        early = (round_reg < 7'd16);
        tj    = sm3_pkg::rotl(early ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH, round_reg[4:0]);
        a12   = sm3_pkg::rotl(r_reg[0], 5'd12);
        ss1   = sm3_pkg::rotl(a12 + r_reg[4] + tj, 5'd7);
        ss2   = ss1 ^ a12;
        ff    = early ? (r_reg[0] ^ r_reg[1] ^ r_reg[2])
                      : ((r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]));
        gg    = early ? (r_reg[4] ^ r_reg[5] ^ r_reg[6])
                      : ((r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]));
        tt1   = ff + r_reg[3] + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2   = gg + r_reg[7] + ss1 + w_reg[0];
        wn    = sm3_pkg::perm1(w_reg[0] ^ w_reg[7] ^ sm3_pkg::rotl(w_reg[13], 5'd15))
              ^ sm3_pkg::rotl(w_reg[3], 5'd7) ^ w_reg[10];
        last_round = (round_reg == 7'd63);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sm3_pkg::ST_IDLE:
                if (cmd_valid)
                begin
                    if (fill_reg == 4'd15)
                        state_next = sm3_pkg::ST_ROUND;
                    else if (cmd.finish)
                        state_next = cmd.pad_next ? sm3_pkg::ST_PADWORD
                                   : (fill_reg == 4'd13) ? sm3_pkg::ST_LEN_HI
                                   : sm3_pkg::ST_ZERO;
                end
            sm3_pkg::ST_ROUND:
                if (last_round)
                    state_next = !finish_reg ? sm3_pkg::ST_IDLE
                               : (bits_reg == 64'd1) ? sm3_pkg::ST_EMIT
                               : pad_next_reg ? sm3_pkg::ST_PADWORD
                               : sm3_pkg::ST_ZERO;
            sm3_pkg::ST_PADWORD:
                state_next = (fill_reg == 4'd15) ? sm3_pkg::ST_ROUND
                           : (fill_reg == 4'd13) ? sm3_pkg::ST_LEN_HI : sm3_pkg::ST_ZERO;
            sm3_pkg::ST_ZERO:
                if (fill_reg == 4'd15)
                    state_next = sm3_pkg::ST_ROUND;
                else if (fill_reg == 4'd13)
                    state_next = sm3_pkg::ST_LEN_HI;
            sm3_pkg::ST_LEN_HI:
                state_next = sm3_pkg::ST_LEN_LO;
            sm3_pkg::ST_LEN_LO:
                state_next = sm3_pkg::ST_ROUND;
            sm3_pkg::ST_EMIT:
                if (pop && !empty_reg && part_reg == 2'd3)
                    state_next = sm3_pkg::ST_IDLE;
            default:
                state_next = sm3_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        load      = 1'b0;
        load_word = 32'd0;
        cmd_take  = 1'b0;
        case (state_reg)
            sm3_pkg::ST_IDLE:
            begin
                cmd_take  = cmd_valid;
                load      = cmd_valid;
                load_word = cmd.word;
            end
            sm3_pkg::ST_PADWORD:
            begin
                load      = 1'b1;
                load_word = {sm3_pkg::PAD_BYTE, 24'd0};
            end
            sm3_pkg::ST_ZERO:
                load = 1'b1;
            sm3_pkg::ST_LEN_HI:
            begin
                load      = 1'b1;
                load_word = bits_reg[63:32];
            end
            sm3_pkg::ST_LEN_LO:
            begin
                load      = 1'b1;
                load_word = bits_reg[31:0];
            end
            default:
                load = 1'b0;
        endcase
        start_cmp = load && (fill_reg == 4'd15);
    end

    assign empty       = empty_reg;
    assign digest_part = {v_reg[{part_reg, 1'b0}], v_reg[{part_reg, 1'b1}]};
    assign part_index  = part_reg;
    assign part_last   = (part_reg == 2'd3);

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
            w_reg[fill_reg] <= load_word;
        else if (state_reg == sm3_pkg::ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wn;
        end
        if (start_cmp)
        begin
            for (int i = 0; i < 8; i++)
                r_reg[i] <= v_reg[i];
        end
        else if (state_reg == sm3_pkg::ST_ROUND)
        begin
            r_reg[0] <= tt1;
            r_reg[1] <= r_reg[0];
            r_reg[2] <= sm3_pkg::rotl(r_reg[1], 5'd9);
            r_reg[3] <= r_reg[2];
            r_reg[4] <= sm3_pkg::perm0(tt2);
            r_reg[5] <= r_reg[4];
            r_reg[6] <= sm3_pkg::rotl(r_reg[5], 5'd19);
            r_reg[7] <= r_reg[6];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sm3_pkg::ST_IDLE;
            fill_reg     <= '0;
            bits_reg     <= '0;
            round_reg    <= '0;
            finish_reg   <= 1'b0;
            pad_next_reg <= 1'b0;
            part_reg     <= '0;
            empty_reg    <= 1'b1;
            for (int i = 0; i < 8; i++)
                v_reg[i] <= sm3_pkg::SM3_IV[255-32*i -: 32];
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                fill_reg <= fill_reg + 1'b1;
            if (state_reg == sm3_pkg::ST_IDLE && cmd_valid)
            begin
                bits_reg     <= bits_reg + {57'd0, cmd_bytes, 3'd0};
                finish_reg   <= cmd.finish;
                pad_next_reg <= cmd.finish && cmd.pad_next;
            end
            if (state_reg == sm3_pkg::ST_PADWORD)
                pad_next_reg <= 1'b0;
            // The final block, with the length already loaded, is flagged by
            // reusing bits_reg's role: the value 1 tracks whether the length went in.
            if (state_reg == sm3_pkg::ST_LEN_LO)
                bits_reg <= 64'd1;
            if (state_reg == sm3_pkg::ST_ROUND)
            begin
                round_reg <= last_round ? 7'd0 : round_reg + 1'b1;
                if (last_round)
                begin
                    for (int i = 0; i < 8; i++)
                        v_reg[i] <= v_reg[i] ^ (i == 0 ? tt1 : i == 1 ? r_reg[0]
                                   : i == 2 ? sm3_pkg::rotl(r_reg[1], 5'd9)
                                   : i == 3 ? r_reg[2] : i == 4 ? sm3_pkg::perm0(tt2)
                                   : i == 5 ? r_reg[4] : i == 6 ? sm3_pkg::rotl(r_reg[5], 5'd19)
                                   : r_reg[6]);
                    if (finish_reg && bits_reg == 64'd1)
                        empty_reg <= 1'b0;
                end
            end
            if (state_reg == sm3_pkg::ST_EMIT && pop && !empty_reg)
            begin
                part_reg <= part_reg + 1'b1;
                if (part_reg == 2'd3)
                begin
                    empty_reg  <= 1'b1;
                    bits_reg   <= '0;
                    finish_reg <= 1'b0;
                    fill_reg   <= '0;
                    for (int i = 0; i < 8; i++)
                        v_reg[i] <= sm3_pkg::SM3_IV[255-32*i -: 32];
                end
            end
        end
    end
endmodule
